### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gbe_pkg.sv
package gbe_pkg;

   localparam int DIV_W    = 4;
   localparam int COLOR_W  = 16;
   localparam int PADDR_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [6:0] HIGHLIGHT_CODE = 7'd94;
   localparam logic [1:0] LAST_BCOL      = 2'd2;   // three bytes per glyph row

   localparam logic [CSR_IDX_W-1:0] REG_TEXT_COLOR      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHLIGHT_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_DIVISOR   = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_BASE  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

### rtl/gbe_channels.sv
interface gbe_req_if;
   import gbe_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] font_byte;
   logic [6:0] glyph_code;
   logic [7:0] origin_x;
   logic [7:0] origin_y;
   logic       glyph_start;

   modport source (output valid, font_byte, glyph_code, origin_x, origin_y, glyph_start,
                   input ready);
   modport sink   (input valid, font_byte, glyph_code, origin_x, origin_y, glyph_start,
                   output ready);
endinterface

interface gbe_rsp_if;
   import gbe_pkg::*;
   logic               valid;
   logic               ready;
   logic [PADDR_W-1:0] pixel_address;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_write;

   modport source (output valid, pixel_address, pixel_color, last_write, input ready);
   modport sink   (input valid, pixel_address, pixel_color, last_write, output ready);
endinterface

### rtl/gbe_serial_div.sv
// Restoring divider, one quotient bit per step, MSB first.
module gbe_serial_div #(
   parameter int W = 9
) (
   input  logic                       clock,
   input  gbe_pkg::div_ctl_type       ctl,
   input  logic [W-1:0]               num_in,
   input  logic [gbe_pkg::DIV_W-1:0]  den,
   output logic [W-1:0]               quot,
   output logic [gbe_pkg::DIV_W-1:0]  rem
);
   import gbe_pkg::*;

   logic [W-1:0]     num_ff, num_in_nx;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;
   logic             qbit;

   always_comb begin
      trial     = {rem_ff, num_ff[W-1]};
      qbit      = (trial >= {1'b0, den});
      num_in_nx = num_ff;
      rem_in    = rem_ff;
      if (ctl.load) begin
         num_in_nx = num_in;
         rem_in    = '0;
      end else if (ctl.step) begin
         num_in_nx = {num_ff[W-2:0], qbit};
         rem_in    = qbit ? DIV_W'(trial - {1'b0, den}) : DIV_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in_nx;
      rem_ff <= rem_in;
   end

   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

### rtl/glyph_byte_expander.sv
// Glyph byte expander: one font byte in, up to eight pixel writes out.
// A new byte is taken only in idle, once the bit-serial row/column divider (SUM_W
// steps) and the scan, one bit per cycle while the output does not stall, are done.
// The last write of a byte is held back and registered from ST_FLUSH; a stall
// on the response side delays it.
// Reset (synchronous, active high) clears FSM, byte position, CSRs and valid flags.
module glyph_byte_expander #(
   parameter int LINE_PIXELS  = 240,
   parameter int GLYPH_ROWS   = 32,
   parameter int FRAME_PIXELS = 57600
) (
   input  logic                          clock,
   input  logic                          reset,
   gbe_req_if.sink                       req_bus,
   gbe_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [gbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbe_pkg::COLOR_W-1:0]   csr_data
);
   import gbe_pkg::*;

   // row counter, row sum (origin_y + row), divider step counter
   localparam int ROW_W    = $clog2(GLYPH_ROWS);
   localparam int SUM_W    = $clog2(255 + GLYPH_ROWS);
   localparam int CNT_W    = $clog2(SUM_W);
   // widest address before the frame check: max row sum * line + origin_x + column
   localparam int MAX_ADDR = (254 + GLYPH_ROWS) * LINE_PIXELS + 255 + 23;
   localparam int SPAN_W   = $clog2(MAX_ADDR + 1);
   // at least one bit above the pixel index, so FRAME_PIXELS itself fits
   localparam int ADDR_W   = (SPAN_W > PADDR_W) ? SPAN_W : PADDR_W + 1;

   // ---------------- configuration registers ----------------
   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic [COLOR_W-1:0] hl_color_ff, hl_color_in;
   logic [DIV_W-1:0]   scale_ff, scale_in;
   logic [DIV_W-1:0]   den;

   always_comb begin
      text_color_in = text_color_ff;
      hl_color_in   = hl_color_ff;
      scale_in      = scale_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TEXT_COLOR:      text_color_in = csr_data;
            REG_HIGHLIGHT_COLOR: hl_color_in   = csr_data;
            REG_SCALE_DIVISOR:   scale_in      = csr_data[DIV_W-1:0];
            default:             ;
         endcase
      end
   end

   // a zero divisor behaves as one
   assign den = (scale_ff == '0) ? DIV_W'(1) : scale_ff;

   // ---------------- control and work registers ----------------
   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;        // glyph row of the next byte
   logic [1:0]         bcol_ff, bcol_in;      // byte column of the next byte
   logic [CNT_W-1:0]   cnt_ff, cnt_in;        // divider steps left
   logic [2:0]         scan_ff, scan_in;      // bit index during scan
   logic [7:0]         bits_ff, bits_in;      // font byte, shifted right per bit
   logic [7:0]         ox_ff, ox_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [ADDR_W-1:0]  base_ff, base_in;      // scaled row * line + origin_x
   logic [4:0]         cq_ff, cq_in;          // column quotient
   logic [DIV_W-1:0]   cr_ff, cr_in;          // column remainder

   // one write held back until we know whether it is the last one
   logic               pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [PADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic               out_last_ff, out_last_in;

   logic               req_take, out_free, keep;
   logic [ADDR_W-1:0]  cur_addr;
   logic [ROW_W-1:0]   row_eff;
   logic [1:0]         bcol_eff;
   div_ctl_type        div_ctl;
   logic [SUM_W-1:0]   row_num, col_num, row_quot, col_quot;
   logic [DIV_W-1:0]   row_rem, col_rem;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   // start mark restarts the glyph at byte 0
   assign row_eff  = req_bus.glyph_start ? '0 : row_ff;
   assign bcol_eff = req_bus.glyph_start ? '0 : bcol_ff;
   assign row_num  = SUM_W'(req_bus.origin_y) + SUM_W'(row_eff);
   assign col_num  = SUM_W'({bcol_eff, 3'b111});   // rightmost column of the byte, bit 0 first

   assign div_ctl.load = req_take;
   assign div_ctl.step = (state_ff == ST_DIV);

   gbe_serial_div #(.W(SUM_W)) u_row_div (
      .clock  (clock),
      .ctl    (div_ctl),
      .num_in (row_num),
      .den    (den),
      .quot   (row_quot),
      .rem    (row_rem)
   );

   gbe_serial_div #(.W(SUM_W)) u_col_div (
      .clock  (clock),
      .ctl    (div_ctl),
      .num_in (col_num),
      .den    (den),
      .quot   (col_quot),
      .rem    (col_rem)
   );

   assign cur_addr = base_ff + ADDR_W'(cq_ff);
   assign keep     = bits_ff[0] && (cur_addr < ADDR_W'(FRAME_PIXELS));

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      bcol_in       = bcol_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      bits_in       = bits_ff;
      ox_in         = ox_ff;
      color_in      = color_ff;
      base_in       = base_ff;
      cq_in         = cq_ff;
      cr_in         = cr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_addr_in   = out_addr_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bits_in  = req_bus.font_byte;
               ox_in    = req_bus.origin_x;
               color_in = (req_bus.glyph_code == HIGHLIGHT_CODE) ? hl_color_ff
                                                                 : text_color_ff;
               cnt_in   = CNT_W'(SUM_W - 1);
               // advance byte position, wrapping after the last glyph byte
               if (bcol_eff == LAST_BCOL) begin
                  bcol_in = '0;
                  row_in  = (row_eff == ROW_W'(GLYPH_ROWS - 1)) ? '0 : row_eff + 1'b1;
               end else begin
                  bcol_in = bcol_eff + 1'b1;
                  row_in  = row_eff;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            base_in  = ADDR_W'(row_quot) * ADDR_W'(LINE_PIXELS) + ADDR_W'(ox_ff);
            cq_in    = col_quot[4:0];
            cr_in    = col_rem;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // stall only when a held write must leave and the output is busy
            if (!(keep && pend_valid_ff && !out_free)) begin
               if (keep) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_addr_in  = pend_addr_ff[PADDR_W-1:0];
                     out_color_in = color_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_addr_in  = cur_addr;
               end
               bits_in = {1'b0, bits_ff[7:1]};
               // step one column to the left
               if (cr_ff == '0) begin
                  cq_in = cq_ff - 1'b1;
                  cr_in = den - 1'b1;
               end else begin
                  cr_in = cr_ff - 1'b1;
               end
               scan_in = scan_ff + 1'b1;
               if (scan_ff == 3'd7) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_addr_in   = pend_addr_ff[PADDR_W-1:0];
               out_color_in  = color_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_W'(65535);
         hl_color_ff   <= COLOR_W'(3457);
         scale_ff      <= DIV_W'(1);
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         bcol_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         text_color_ff <= text_color_in;
         hl_color_ff   <= hl_color_in;
         scale_ff      <= scale_in;
         state_ff      <= state_in;
         row_ff        <= row_in;
         bcol_ff       <= bcol_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      scan_ff      <= scan_in;
      bits_ff      <= bits_in;
      ox_ff        <= ox_in;
      color_ff     <= color_in;
      base_ff      <= base_in;
      cq_ff        <= cq_in;
      cr_ff        <= cr_in;
      pend_addr_ff <= pend_addr_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   // color travels with the write: the next byte may be taken while the
   // last write of this one still waits in the output register
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pixel_address = out_addr_ff;
   assign rsp_bus.pixel_color   = out_color_ff;
   assign rsp_bus.last_write    = out_last_ff;

   // unused divider remainder of the row path is intentional
   logic row_rem_unused;
   assign row_rem_unused = ^row_rem;

endmodule

### rtl/gbe_checker.sv
`include "assert_macros.svh"

module gbe_checker #(
   parameter int FRAME_PIXELS = 57600
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_addr,
   input logic [15:0] rsp_color,
   input logic        rsp_last
);

   `GBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `GBE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_addr) && $stable(rsp_color) && $stable(rsp_last), "rsp payload changed while stalled")
   `GBE_ASSERT_NEXT(a_one_byte, clock, reset, req_valid && req_ready, !req_ready, "second byte taken while busy")
   `GBE_ASSERT_NOW(a_in_frame, clock, reset, rsp_valid, {16'd0, rsp_addr} < FRAME_PIXELS, "write outside frame")

endmodule

bind glyph_byte_expander gbe_checker #(.FRAME_PIXELS(FRAME_PIXELS)) u_gbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_addr  (rsp_bus.pixel_address),
   .rsp_color (rsp_bus.pixel_color),
   .rsp_last  (rsp_bus.last_write)
);
